// ----- sv/rdc_pkg.sv -----
package rdc_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int CHUNK_W     = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] TEN         = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'd65;

  // sequencer step address and jump conditions
  typedef logic [2:0] pc_t;
  typedef logic [2:0] cond_t;

  localparam cond_t C_NEVER       = 3'd0;
  localparam cond_t C_ALWAYS      = 3'd1;
  localparam cond_t C_NO_IN       = 3'd2;
  localparam cond_t C_MORE_CHUNKS = 3'd3;
  localparam cond_t C_Q_NZ        = 3'd4;
  localparam cond_t C_OUT_BLOCKED = 3'd5;
  localparam cond_t C_LEVEL_ZERO  = 3'd6;

  localparam pc_t PC_IDLE  = 3'd0;
  localparam pc_t PC_DIV   = 3'd1;
  localparam pc_t PC_PUSH  = 3'd2;
  localparam pc_t PC_POP   = 3'd3;
  localparam pc_t PC_EMIT  = 3'd4;
  localparam pc_t PC_TEST  = 3'd5;
  localparam pc_t PC_POP2  = 3'd6;

  typedef struct packed {
    logic  accept;
    logic  div_step;
    logic  push;
    logic  pop;
    logic  emit;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // control to the divide unit
  typedef struct packed {
    logic load;
    logic step;
    logic clr_rem;
  } div_ctrl_t;

  // status from the divide unit
  typedef struct packed {
    logic q_nz;
    logic last_chunk;
  } div_stat_t;

  // microprogram: on a true condition go to target, else to the next step
  function automatic uword_t uc_rom(input pc_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      PC_IDLE: begin
        w.accept = 1'b1; w.cond = C_NO_IN;       w.target = PC_IDLE;
      end
      PC_DIV: begin
        w.div_step = 1'b1; w.cond = C_MORE_CHUNKS; w.target = PC_DIV;
      end
      PC_PUSH: begin
        w.push = 1'b1; w.cond = C_Q_NZ;         w.target = PC_DIV;
      end
      PC_POP: begin
        w.pop = 1'b1; w.cond = C_NEVER;         w.target = PC_IDLE;
      end
      PC_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_BLOCKED;  w.target = PC_EMIT;
      end
      PC_TEST: begin
        w.cond = C_LEVEL_ZERO;                  w.target = PC_IDLE;
      end
      PC_POP2: begin
        w.pop = 1'b1; w.cond = C_ALWAYS;        w.target = PC_EMIT;
      end
      default: begin
        w.cond = C_ALWAYS;                      w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    if (d < TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - TEN);
  endfunction

endpackage

// ----- sv/rdc_ram.sv -----
module rdc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/rdc_div_unit.sv -----
module rdc_div_unit
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_ctrl_t             ctrl,
  input  logic [VALUE_BITS-1:0] load_value,
  input  logic [RADIX_W-1:0]    radix,
  output div_stat_t             stat,
  output logic [DIGIT_W-1:0]    rem
);

  localparam int NCHUNK = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int QW     = NCHUNK * CHUNK_W;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [CW-1:0] LAST_CHUNK = CW'(NCHUNK - 1);

  logic [QW-1:0]      q_r, q_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]      chunk_r, chunk_nxt;
  logic [CHUNK_W-1:0] top_byte, q_byte;
  logic [DIGIT_W-1:0] r_div;
  logic [DIGIT_W:0]   t;

  // one byte of long division: eight restoring compare-subtract steps
  always_comb begin
    top_byte = q_r[QW-1 -: CHUNK_W];
    r_div    = rem_r;
    q_byte   = '0;
    t        = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      t = {r_div, top_byte[i]};
      if (t >= {1'b0, radix}) begin
        t         = t - {1'b0, radix};
        q_byte[i] = 1'b1;
      end
      r_div = t[DIGIT_W-1:0];
    end
  end

  always_comb begin
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    if (ctrl.load) begin
      q_nxt     = QW'(load_value);
      rem_nxt   = '0;
      chunk_nxt = '0;
    end else if (ctrl.step) begin
      q_nxt     = QW'({q_r, q_byte});
      rem_nxt   = r_div;
      chunk_nxt = (chunk_r == LAST_CHUNK) ? '0 : chunk_r + 1'b1;
    end else if (ctrl.clr_rem) begin
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
    end else begin
      chunk_r <= chunk_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.q_nz       = |q_r;
  assign stat.last_chunk = (chunk_r == LAST_CHUNK);
  assign rem             = rem_r;

endmodule

// ----- sv/radix_digit_converter.sv -----
// operation: after an input transfer the byte-wide divide unit (one byte of quotient per cycle)
//   divides by the radix, and each remainder is pushed on the digit stack as one digit; the
//   digits are then popped and emitted most significant first, and a new number is taken only
//   once the last digit has been loaded into the output register
// reset: synchronous active-low rst_n clears the sequencer, stack level, output valid,
//   and sets the radix to 10; the digit stack holds no reset value
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS  = 63,
  parameter int STACK_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream: tdata bits [62:0] number, bit 63 zero
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream: tdata bits [6:0] digit_char, bit 7 zero; tlast is last_digit
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // radix write: cfg_data bits [5:0] radix, bits [7:6] ignored
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int LVW = $clog2(STACK_DEPTH + 1);
  localparam logic [LVW-1:0] DEPTH_L = LVW'(STACK_DEPTH);

  // sequencer state
  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   cond_hit;

  // radix register, stored already clamped to 2..36
  logic [RADIX_W-1:0] radix_r, radix_nxt, cfg_radix;

  // digit stack bookkeeping
  logic [LVW-1:0]     level_r, level_nxt, level_dec;
  logic               push_en, pop_en;
  logic [DIGIT_W-1:0] stack_rd;

  // divider interface
  div_ctrl_t          dctrl;
  div_stat_t          dstat;
  logic [DIGIT_W-1:0] rem;

  // output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              out_blocked, out_load;
  logic              in_xfer;

  assign uw          = uc_rom(pc_r);
  assign in_tready   = uw.accept;
  assign in_xfer     = in_tvalid & in_tready;
  assign out_blocked = out_valid_r & ~out_tready;
  assign out_load    = uw.emit & ~out_blocked;
  assign level_dec   = level_r - 1'b1;
  // pushes beyond the stack depth drop the extra high digits
  assign push_en     = uw.push & (level_r < DEPTH_L);
  assign pop_en      = uw.pop;

  // condition select for the jump
  always_comb begin
    case (uw.cond)
      C_NEVER:       cond_hit = 1'b0;
      C_ALWAYS:      cond_hit = 1'b1;
      C_NO_IN:       cond_hit = ~in_xfer;
      C_MORE_CHUNKS: cond_hit = ~dstat.last_chunk;
      C_Q_NZ:        cond_hit = dstat.q_nz;
      C_OUT_BLOCKED: cond_hit = out_blocked;
      C_LEVEL_ZERO:  cond_hit = (level_r == '0);
      default:       cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? uw.target : pc_r + 1'b1;
  end

  // divider control: load on input transfer, clear the remainder after each push
  assign dctrl.load    = in_xfer;
  assign dctrl.step    = uw.div_step;
  assign dctrl.clr_rem = uw.push;

  always_comb begin
    level_nxt = level_r;
    if (in_xfer) begin
      level_nxt = '0;
    end else if (push_en) begin
      level_nxt = level_r + 1'b1;
    end else if (pop_en) begin
      level_nxt = level_dec;
    end
  end

  // out of range radix values are folded into 2..36 at write time
  assign cfg_ready = 1'b1;
  assign cfg_radix = cfg_data[RADIX_W-1:0];
  always_comb begin
    radix_nxt = radix_r;
    if (cfg_valid) begin
      if (cfg_radix < RADIX_MIN) begin
        radix_nxt = RADIX_MIN;
      end else if (cfg_radix > RADIX_MAX) begin
        radix_nxt = RADIX_MAX;
      end else begin
        radix_nxt = cfg_radix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      level_r     <= '0;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      level_r <= level_nxt;
      radix_r <= radix_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload; the level is already decremented, so zero marks the last digit
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r <= digit_to_char(stack_rd);
      out_last_r <= (level_r == '0);
    end
  end

  rdc_div_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (dctrl),
    .load_value (in_tdata[VALUE_BITS-1:0]),
    .radix      (radix_r),
    .stat       (dstat),
    .rem        (rem)
  );

  // digit stack; a pop reads the top entry, data is ready in the emit step
  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (level_r[AW-1:0]),
    .wr_data (rem),
    .rd_en   (pop_en),
    .rd_addr (level_dec[AW-1:0]),
    .rd_data (stack_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/rdc_checker.sv -----
module rdc_checker
  import rdc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // no new item is taken in the cycle right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // every digit is an ascii digit or capital letter
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7] == 1'b0) &&
      ((out_tdata[6:0] >= 7'd48 && out_tdata[6:0] <= 7'd57) ||
       (out_tdata[6:0] >= 7'd65 && out_tdata[6:0] <= 7'd90)))
    else $error("digit character out of range");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output payload changed while stalled");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rdc_pkg::*;

  // bound on the whole run, far above the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // extra wait after the last digit so the block can finish its bookkeeping
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned MAX_PRINTED = 100;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } digit_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  digit_t             pending_digits[$];
  logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  logic               hold_active = 1'b0;
  int unsigned        err_count = 0;
  int unsigned        cycle_count = 0;

  radix_digit_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, forced low during a long hold-off
  always @(posedge clk) begin
    if (hold_active) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h",
               cycle_count, what, got, want);
    end
    err_count++;
  endtask

  // repeated division by the clamped radix, digits queued most significant first
  function automatic void predict_digits(input logic [62:0] number,
                                         input logic [RADIX_W-1:0] radix_reg);
    logic [62:0]        quot;
    logic [62:0]        base;
    logic [DIGIT_W-1:0] stack[$];
    logic [DIGIT_W-1:0] d;
    digit_t             item;
    if (radix_reg < RADIX_MIN) begin
      base = 63'(RADIX_MIN);
    end else if (radix_reg > RADIX_MAX) begin
      base = 63'(RADIX_MAX);
    end else begin
      base = 63'(radix_reg);
    end
    quot = number;
    // zero still yields one digit
    do begin
      stack.push_back(DIGIT_W'(quot % base));
      quot = quot / base;
    end while (quot != 0);
    while (stack.size() != 0) begin
      d = stack.pop_back();
      item.char_code = (d < TEN) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - TEN);
      item.last      = (stack.size() == 0);
      pending_digits.push_back(item);
    end
  endfunction

  // one process watches all three channels so ordering within a step never matters
  always @(posedge clk) begin
    digit_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        radix_shadow = cfg_data[RADIX_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        predict_digits(in_tdata[62:0], radix_shadow);
      end
      if (out_tvalid && out_tready) begin
        if (pending_digits.size() == 0) begin
          report_mismatch("digit with nothing pending", 64'(out_tdata), 64'd0);
        end else begin
          want = pending_digits.pop_front();
          if (out_tdata !== {1'b0, want.char_code}) begin
            report_mismatch("digit char", 64'(out_tdata), 64'(want.char_code));
          end
          if (out_tlast !== want.last) begin
            report_mismatch("last digit flag", 64'(out_tlast), 64'(want.last));
          end
        end
      end
    end
  end

  // offer one number, idling first at the current rate, return after the transfer
  task automatic send_number(input logic [62:0] number);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, number};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every digit has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [62:0] rand_number();
    logic [62:0] n;
    int unsigned len;
    n = 63'({$urandom, $urandom});
    case ($urandom_range(7))
      0: n = 63'($urandom_range(40));
      1: n = '1;
      2, 3: begin
        len = $urandom_range(1, 20);
        n = n & ((63'd1 << len) - 63'd1);
      end
      default: begin
        len = $urandom_range(1, 63);
        n = n & ((63'd1 << len) - 63'd1);
      end
    endcase
    return n;
  endfunction

  // mostly legal radixes, sometimes any byte including the clamped ranges
  function automatic logic [CFG_DATA_W-1:0] rand_radix();
    if ($urandom_range(3) == 0) begin
      return CFG_DATA_W'($urandom_range(255));
    end
    return {2'($urandom), 6'($urandom_range(2, 36))};
  endfunction

  // reset radix of ten with no write at all
  task automatic test_reset_radix();
    send_number(63'd0);
    send_number(63'd1);
    send_number(63'd9);
    send_number(63'd10);
    send_number(63'd99);
    send_number(63'd100);
    send_number(63'd12345);
    send_number('1);
  endtask

  // range ends of the radix, out-of-range radixes, ignored upper config bits
  task automatic test_radix_extremes();
    write_radix(8'd2);
    send_number(63'd0);
    send_number(63'd2);
    send_number('1);
    send_number(63'h4000_0000_0000_0000);
    write_radix(8'd36);
    send_number(63'd35);
    send_number(63'd36);
    send_number('1);
    write_radix(8'd16);
    send_number(63'h2aaa_aaaa_5555_5555);
    // below two acts as two
    write_radix(8'd0);
    send_number(63'd5);
    write_radix(8'd1);
    send_number(63'd6);
    // above thirty-six acts as thirty-six
    write_radix(8'd37);
    send_number(63'd1295);
    write_radix(8'd63);
    send_number(63'd46655);
    // upper two bits of the write data are don't-care
    write_radix(8'hca);
    send_number(63'd255);
  endtask

  // receiver stops for a long stretch while numbers keep coming, then a full pause
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_radix(8'd36);
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
      begin
        repeat (10) send_number(63'($urandom_range(100000)));
      end
    join
    wait_drained();
    repeat (4) send_number(rand_number());
  endtask

  // random numbers, radix changed every 20 transfers
  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned count);
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        write_radix(rand_radix());
      end
      send_number(rand_number());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_radix();
    test_radix_extremes();
    test_backpressure();
    test_random(13, 53, 60);
    test_random(53, 13, 60);
    test_random(0, 0, 60);
    wait_drained();
    if (err_count == 0 && pending_digits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
